// ----- rtl/core/iaub_pkg.sv -----
package iaub_pkg;

  localparam int COORD_W = 16;
  localparam int CHAN_W = 8;
  localparam int ALPHA_W = 9;
  localparam int NCHAN = 3;

  localparam int NUM_W = 16;
  localparam int DEN_W = 9;
  localparam int QUOT_W = 8;
  localparam int DIV_STAGES = 4;
  localparam int DIV_STEPS = QUOT_W / DIV_STAGES;

  localparam int LATENCY = DIV_STAGES + 3;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               uns;
    logic [NCHAN-1:0]   sat_hi;
    logic [NCHAN-1:0]   sat_lo;
  } side_t;

endpackage

// ----- rtl/core/inverse_alpha_unblend_unit.sv -----
// Inverse "over" compositing: recovers the original RGBA pixel from a
// blended pixel and the known overlay pixel at the same coordinates.
//
// Request channel: drive the pixel fields and raise start for one cycle
// per request; a request is taken at a rising edge with start high and
// busy low. Result channel: done is high for exactly one cycle with all
// result fields valid in that cycle; the receiver cannot stall it.
//
// Two arithmetic stages (products, then signed difference with
// saturation checks) feed four pipelined restoring dividers, two
// quotient bits per stage, then an output register. One pixel per
// cycle is taken while busy is low.
//
// Reset (rst, synchronous) drops every request in flight; busy is rst
// registered: high in the cycle after rst is high, and low otherwise.
// unsolvable marks blend_alpha <= mark_alpha and forces zero colours and
// alpha; clamped marks a colour quotient saturated to 0 or 255.
module inverse_alpha_unblend_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [iaub_pkg::COORD_W-1:0]    pixel_x,
  input  logic [iaub_pkg::COORD_W-1:0]    pixel_y,
  input  logic [iaub_pkg::CHAN_W-1:0]     blend_red,
  input  logic [iaub_pkg::CHAN_W-1:0]     blend_green,
  input  logic [iaub_pkg::CHAN_W-1:0]     blend_blue,
  input  logic [iaub_pkg::CHAN_W-1:0]     blend_alpha,
  input  logic [iaub_pkg::CHAN_W-1:0]     mark_red,
  input  logic [iaub_pkg::CHAN_W-1:0]     mark_green,
  input  logic [iaub_pkg::CHAN_W-1:0]     mark_blue,
  input  logic [iaub_pkg::CHAN_W-1:0]     mark_alpha,
  output logic                            done,
  output logic [iaub_pkg::COORD_W-1:0]    out_x,
  output logic [iaub_pkg::COORD_W-1:0]    out_y,
  output logic [iaub_pkg::CHAN_W-1:0]     clean_red,
  output logic [iaub_pkg::CHAN_W-1:0]     clean_green,
  output logic [iaub_pkg::CHAN_W-1:0]     clean_blue,
  output logic [iaub_pkg::ALPHA_W-1:0]    clean_alpha,
  output logic                            unsolvable,
  output logic                            clamped
);
  import iaub_pkg::*;

  logic accept;
  logic [CHAN_W-1:0] blend_c [NCHAN];
  logic [CHAN_W-1:0] mark_c  [NCHAN];

  logic                 s1_vld;
  logic [COORD_W-1:0]   s1_x;
  logic [COORD_W-1:0]   s1_y;
  logic                 s1_uns;
  logic [CHAN_W-1:0]    s1_den;
  logic [DEN_W-1:0]     s1_aden;
  logic [2*CHAN_W-1:0]  s1_pb [NCHAN];
  logic [2*CHAN_W-1:0]  s1_pm [NCHAN];

  logic                 s2_vld;
  side_t                s2_side;
  side_t                s2_side_next;
  logic [NUM_W-1:0]     s2_num [NCHAN];
  logic [NUM_W-1:0]     s2_num_next [NCHAN];
  logic [DEN_W-1:0]     s2_den;
  logic [NUM_W-1:0]     s2_anum;
  logic [DEN_W-1:0]     s2_aden;

  logic                 vld_q  [DIV_STAGES];
  side_t                side_q [DIV_STAGES];

  logic [QUOT_W-1:0]    quot_c [NCHAN];
  logic [QUOT_W-1:0]    quot_a;
  logic [CHAN_W-1:0]    color_next [NCHAN];
  side_t                fin;

  assign accept = start && !busy;

  assign blend_c[0] = blend_red;
  assign blend_c[1] = blend_green;
  assign blend_c[2] = blend_blue;
  assign mark_c[0]  = mark_red;
  assign mark_c[1]  = mark_green;
  assign mark_c[2]  = mark_blue;

  always_ff @(posedge clk) begin
    busy <= rst;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
      s2_vld <= 1'b0;
      for (int s = 0; s < DIV_STAGES; s++) begin
        vld_q[s] <= 1'b0;
      end
      done <= 1'b0;
    end else begin
      s1_vld <= accept;
      s2_vld <= s1_vld;
      vld_q[0] <= s2_vld;
      for (int s = 1; s < DIV_STAGES; s++) begin
        vld_q[s] <= vld_q[s-1];
      end
      done <= vld_q[DIV_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    s1_x    <= pixel_x;
    s1_y    <= pixel_y;
    s1_uns  <= (blend_alpha <= mark_alpha);
    s1_den  <= blend_alpha - mark_alpha;
    s1_aden <= DEN_W'(9'd256 - {1'b0, mark_alpha});
    for (int c = 0; c < NCHAN; c++) begin
      s1_pb[c] <= (2*CHAN_W)'(blend_alpha) * (2*CHAN_W)'(blend_c[c]);
      s1_pm[c] <= (2*CHAN_W)'(mark_alpha) * (2*CHAN_W)'(mark_c[c]);
    end
  end

  always_comb begin
    logic [2*CHAN_W:0] diff;
    logic [NUM_W-1:0]  mag;
    logic              neg;
    logic              hi;
    logic              lo;
    s2_side_next.x   = s1_x;
    s2_side_next.y   = s1_y;
    s2_side_next.uns = s1_uns;
    s2_side_next.sat_hi = '0;
    s2_side_next.sat_lo = '0;
    for (int c = 0; c < NCHAN; c++) begin
      diff = {1'b0, s1_pb[c]} - {1'b0, s1_pm[c]};
      neg  = diff[2*CHAN_W];
      mag  = neg ? NUM_W'(-diff) : diff[NUM_W-1:0];
      lo   = neg && (mag >= NUM_W'(s1_den));
      hi   = !neg && (mag >= {s1_den, 8'h00});
      s2_side_next.sat_hi[c] = hi;
      s2_side_next.sat_lo[c] = lo;
      s2_num_next[c] = (neg || hi) ? '0 : mag;
    end
  end

  always_ff @(posedge clk) begin
    s2_side <= s2_side_next;
    s2_den  <= DEN_W'(s1_den);
    s2_anum <= {s1_den, 8'h00};
    s2_aden <= s1_aden;
    for (int c = 0; c < NCHAN; c++) begin
      s2_num[c] <= s2_num_next[c];
    end
  end

  for (genvar c = 0; c < NCHAN; c++) begin : g_chan
    iaub_divider u_div (
      .clk  (clk),
      .num  (s2_num[c]),
      .den  (s2_den),
      .quot (quot_c[c])
    );
  end

  iaub_divider u_div_alpha (
    .clk  (clk),
    .num  (s2_anum),
    .den  (s2_aden),
    .quot (quot_a)
  );

  always_ff @(posedge clk) begin
    side_q[0] <= s2_side;
    for (int s = 1; s < DIV_STAGES; s++) begin
      side_q[s] <= side_q[s-1];
    end
  end

  assign fin = side_q[DIV_STAGES-1];

  always_comb begin
    for (int c = 0; c < NCHAN; c++) begin
      if (fin.uns || fin.sat_lo[c]) begin
        color_next[c] = '0;
      end else if (fin.sat_hi[c]) begin
        color_next[c] = '1;
      end else begin
        color_next[c] = quot_c[c];
      end
    end
  end

  always_ff @(posedge clk) begin
    out_x       <= fin.x;
    out_y       <= fin.y;
    clean_red   <= color_next[0];
    clean_green <= color_next[1];
    clean_blue  <= color_next[2];
    clean_alpha <= fin.uns ? '0 : ALPHA_W'(quot_a);
    unsolvable  <= fin.uns;
    clamped     <= !fin.uns && ((fin.sat_hi | fin.sat_lo) != '0);
  end

endmodule

// ----- rtl/core/iaub_divider.sv -----
module iaub_divider (
  input  logic                          clk,
  input  logic [iaub_pkg::NUM_W-1:0]    num,
  input  logic [iaub_pkg::DEN_W-1:0]    den,
  output logic [iaub_pkg::QUOT_W-1:0]   quot
);
  import iaub_pkg::*;

  logic [NUM_W-1:0]  rem_q  [DIV_STAGES];
  logic [DEN_W-1:0]  den_q  [DIV_STAGES];
  logic [QUOT_W-1:0] quo_q  [DIV_STAGES];
  logic [NUM_W-1:0]  rem_next [DIV_STAGES];
  logic [DEN_W-1:0]  den_next [DIV_STAGES];
  logic [QUOT_W-1:0] quo_next [DIV_STAGES];

  always_comb begin
    logic [NUM_W-1:0]  r;
    logic [NUM_W-1:0]  sh;
    logic [DEN_W-1:0]  d;
    logic [QUOT_W-1:0] q;
    int idx;
    for (int s = 0; s < DIV_STAGES; s++) begin
      r = num;
      d = den;
      q = '0;
      if (s > 0) begin
        r = rem_q[s-1];
        d = den_q[s-1];
        q = quo_q[s-1];
      end
      for (int k = 0; k < DIV_STEPS; k++) begin
        idx = QUOT_W - 1 - s * DIV_STEPS - k;
        sh = NUM_W'(d) << idx;
        if (r >= sh) begin
          r = r - sh;
          q[idx] = 1'b1;
        end
      end
      rem_next[s] = r;
      den_next[s] = d;
      quo_next[s] = q;
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < DIV_STAGES; s++) begin
      rem_q[s] <= rem_next[s];
      den_q[s] <= den_next[s];
      quo_q[s] <= quo_next[s];
    end
  end

  assign quot = quo_q[DIV_STAGES-1];

endmodule

// ----- rtl/core/iaub_checker.sv -----
module iaub_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic                            busy,
  input  logic [iaub_pkg::COORD_W-1:0]    pixel_x,
  input  logic [iaub_pkg::COORD_W-1:0]    pixel_y,
  input  logic                            done,
  input  logic [iaub_pkg::COORD_W-1:0]    out_x,
  input  logic [iaub_pkg::COORD_W-1:0]    out_y,
  input  logic [iaub_pkg::CHAN_W-1:0]     clean_red,
  input  logic [iaub_pkg::CHAN_W-1:0]     clean_green,
  input  logic [iaub_pkg::CHAN_W-1:0]     clean_blue,
  input  logic [iaub_pkg::ALPHA_W-1:0]    clean_alpha,
  input  logic                            unsolvable,
  input  logic                            clamped
);
  import iaub_pkg::*;

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LATENCY (done && out_x == $past(pixel_x, LATENCY)
                                         && out_y == $past(pixel_y, LATENCY)))
    else $error("missing or misaligned result");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LATENCY))
    else $error("result without request");

  a_unsolvable_zero: assert property (@(posedge clk) disable iff (rst)
    (done && unsolvable) |-> (clean_red == '0 && clean_green == '0 &&
                              clean_blue == '0 && clean_alpha == '0 && !clamped))
    else $error("unsolvable result not zeroed");

  a_alpha_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (clean_alpha[ALPHA_W-1] == 1'b0))
    else $error("recovered alpha out of range");

endmodule

bind inverse_alpha_unblend_unit iaub_checker u_iaub_checker (.*);

// ----- tb/tb.sv -----
module tb;
  import iaub_pkg::*;

  typedef struct {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [CHAN_W-1:0]  br;
    logic [CHAN_W-1:0]  bg;
    logic [CHAN_W-1:0]  bb;
    logic [CHAN_W-1:0]  ba;
    logic [CHAN_W-1:0]  mr;
    logic [CHAN_W-1:0]  mg;
    logic [CHAN_W-1:0]  mb;
    logic [CHAN_W-1:0]  ma;
  } pixel_req_t;

  typedef struct {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [CHAN_W-1:0]  r;
    logic [CHAN_W-1:0]  g;
    logic [CHAN_W-1:0]  b;
    logic [ALPHA_W-1:0] a;
    logic               uns;
    logic               clp;
  } clean_pixel_t;

  class clean_pixel_board;
    clean_pixel_t pending_pixels[$];
    int failures = 0;

    function void note_request(clean_pixel_t exp_pix);
      pending_pixels.push_back(exp_pix);
    endfunction

    function void cmp(string field, logic [31:0] exp_v, logic [31:0] act_v);
      if (act_v !== exp_v) begin
        $error("%s: expected %0d, got %0d", field, exp_v, act_v);
        failures++;
      end
    endfunction

    function void check_result(clean_pixel_t act);
      clean_pixel_t exp_pix;
      if (pending_pixels.size() == 0) begin
        $error("result with no request outstanding");
        failures++;
        return;
      end
      exp_pix = pending_pixels.pop_front();
      cmp("out_x", 32'(exp_pix.x), 32'(act.x));
      cmp("out_y", 32'(exp_pix.y), 32'(act.y));
      cmp("clean_red", 32'(exp_pix.r), 32'(act.r));
      cmp("clean_green", 32'(exp_pix.g), 32'(act.g));
      cmp("clean_blue", 32'(exp_pix.b), 32'(act.b));
      cmp("clean_alpha", 32'(exp_pix.a), 32'(act.a));
      cmp("unsolvable", 32'(exp_pix.uns), 32'(act.uns));
      cmp("clamped", 32'(exp_pix.clp), 32'(act.clp));
    endfunction

    function int outstanding();
      return pending_pixels.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [COORD_W-1:0] pixel_x = '0;
  logic [COORD_W-1:0] pixel_y = '0;
  logic [CHAN_W-1:0] blend_red = '0;
  logic [CHAN_W-1:0] blend_green = '0;
  logic [CHAN_W-1:0] blend_blue = '0;
  logic [CHAN_W-1:0] blend_alpha = '0;
  logic [CHAN_W-1:0] mark_red = '0;
  logic [CHAN_W-1:0] mark_green = '0;
  logic [CHAN_W-1:0] mark_blue = '0;
  logic [CHAN_W-1:0] mark_alpha = '0;
  logic done;
  logic [COORD_W-1:0] out_x;
  logic [COORD_W-1:0] out_y;
  logic [CHAN_W-1:0] clean_red;
  logic [CHAN_W-1:0] clean_green;
  logic [CHAN_W-1:0] clean_blue;
  logic [ALPHA_W-1:0] clean_alpha;
  logic unsolvable;
  logic clamped;

  clean_pixel_board board = new();

  inverse_alpha_unblend_unit u_top (
    .clk, .rst, .start, .busy,
    .pixel_x, .pixel_y,
    .blend_red, .blend_green, .blend_blue, .blend_alpha,
    .mark_red, .mark_green, .mark_blue, .mark_alpha,
    .done, .out_x, .out_y,
    .clean_red, .clean_green, .clean_blue, .clean_alpha,
    .unsolvable, .clamped
  );

  always #5 clk = ~clk;

  function automatic logic [CHAN_W-1:0] clean_channel(input int da, input int wa,
                                                      input int d, input int w,
                                                      inout bit clip);
    int num;
    int quo;
    num = da * d - wa * w;
    quo = num / (da - wa);
    if (quo < 0) begin
      clip = 1'b1;
      return '0;
    end
    if (quo > 255) begin
      clip = 1'b1;
      return 8'hFF;
    end
    return quo[CHAN_W-1:0];
  endfunction

  function automatic clean_pixel_t unblend_pixel(pixel_req_t q);
    clean_pixel_t res;
    int da;
    int wa;
    int alpha_q;
    bit clip;
    da = int'(q.ba);
    wa = int'(q.ma);
    clip = 1'b0;
    res.x = q.x;
    res.y = q.y;
    if (da <= wa) begin
      res.r = '0;
      res.g = '0;
      res.b = '0;
      res.a = '0;
      res.uns = 1'b1;
      res.clp = 1'b0;
      return res;
    end
    res.r = clean_channel(da, wa, int'(q.br), int'(q.mr), clip);
    res.g = clean_channel(da, wa, int'(q.bg), int'(q.mg), clip);
    res.b = clean_channel(da, wa, int'(q.bb), int'(q.mb), clip);
    alpha_q = (256 * (da - wa)) / (256 - wa);
    res.a = alpha_q[ALPHA_W-1:0];
    res.uns = 1'b0;
    res.clp = clip;
    return res;
  endfunction

  function automatic pixel_req_t req_of(int x, int y, int br, int bg, int bb, int ba,
                                        int mr, int mg, int mb, int ma);
    pixel_req_t q;
    q.x = x[COORD_W-1:0];
    q.y = y[COORD_W-1:0];
    q.br = br[CHAN_W-1:0];
    q.bg = bg[CHAN_W-1:0];
    q.bb = bb[CHAN_W-1:0];
    q.ba = ba[CHAN_W-1:0];
    q.mr = mr[CHAN_W-1:0];
    q.mg = mg[CHAN_W-1:0];
    q.mb = mb[CHAN_W-1:0];
    q.ma = ma[CHAN_W-1:0];
    return q;
  endfunction

  function automatic pixel_req_t random_req();
    pixel_req_t q;
    int mode;
    int wa;
    int da;
    mode = $urandom_range(0, 99);
    if (mode < 70) begin
      wa = $urandom_range(0, 254);
      da = $urandom_range(wa + 1, 255);
    end else if (mode < 80) begin
      wa = $urandom_range(0, 254);
      da = (mode < 75) ? 255 : wa + 1;
    end else if (mode < 90) begin
      da = $urandom_range(0, 255);
      wa = $urandom_range(da, 255);
    end else begin
      da = $urandom_range(0, 255);
      wa = $urandom_range(0, 255);
    end
    q = req_of($urandom, $urandom,
               $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255), da,
               $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255), wa);
    return q;
  endfunction

  task automatic send(pixel_req_t q);
    pixel_x <= q.x;
    pixel_y <= q.y;
    blend_red <= q.br;
    blend_green <= q.bg;
    blend_blue <= q.bb;
    blend_alpha <= q.ba;
    mark_red <= q.mr;
    mark_green <= q.mg;
    mark_blue <= q.mb;
    mark_alpha <= q.ma;
    start <= 1'b1;
    do @(posedge clk); while (busy);
  endtask

  task automatic maybe_idle(bit quiet);
    if (!quiet && $urandom_range(0, 99) < 8) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  always @(posedge clk) begin
    pixel_req_t q;
    if (!rst && start && !busy) begin
      q = req_of(int'(pixel_x), int'(pixel_y), int'(blend_red), int'(blend_green),
                 int'(blend_blue), int'(blend_alpha), int'(mark_red), int'(mark_green),
                 int'(mark_blue), int'(mark_alpha));
      board.note_request(unblend_pixel(q));
    end
  end

  always @(posedge clk) begin
    clean_pixel_t act;
    if (!rst && done) begin
      act.x = out_x;
      act.y = out_y;
      act.r = clean_red;
      act.g = clean_green;
      act.b = clean_blue;
      act.a = clean_alpha;
      act.uns = unsolvable;
      act.clp = clamped;
      board.check_result(act);
    end
  end

  initial begin
    pixel_req_t directed[$];
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    directed.push_back(req_of(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    directed.push_back(req_of(16'hFFFF, 16'hFFFF, 255, 255, 255, 255, 255, 255, 255, 255));
    directed.push_back(req_of(12, 34, 90, 180, 45, 10, 200, 17, 99, 200));
    directed.push_back(req_of(16'hAAAA, 16'h5555, 0, 128, 255, 255, 77, 201, 3, 0));
    directed.push_back(req_of(16'h5555, 16'hAAAA, 255, 0, 128, 255, 0, 255, 128, 254));
    directed.push_back(req_of(1, 2, 255, 0, 17, 1, 0, 255, 200, 0));
    directed.push_back(req_of(3, 4, 0, 0, 0, 3, 1, 1, 1, 1));
    directed.push_back(req_of(5, 6, 0, 255, 128, 200, 255, 0, 128, 100));
    directed.push_back(req_of(7, 8, 200, 100, 50, 255, 10, 20, 30, 1));
    directed.push_back(req_of(9, 10, 129, 127, 250, 128, 130, 120, 5, 127));
    directed.push_back(req_of(11, 12, 255, 255, 255, 255, 255, 255, 255, 254));
    directed.push_back(req_of(13, 14, 0, 0, 0, 255, 255, 255, 255, 254));
    directed.push_back(req_of(15, 16, 100, 100, 100, 2, 50, 200, 100, 1));
    directed.push_back(req_of(16'hFFFF, 0, 1, 254, 127, 0, 255, 255, 255, 255));
    directed.push_back(req_of(0, 16'hFFFF, 128, 64, 32, 100, 128, 64, 32, 99));
    foreach (directed[i]) begin
      send(directed[i]);
      maybe_idle(1'b0);
    end

    for (int n = 0; n < 1950; n++) begin
      send(random_req());
      maybe_idle(n >= 700 && n < 1200);
    end
    start <= 1'b0;

    while (board.outstanding() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
    if (board.failures == 0) begin
      $display("inverse_alpha_unblend_unit: match");
    end else begin
      $display("inverse_alpha_unblend_unit: mismatch");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("inverse_alpha_unblend_unit: mismatch");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/iaub_pkg.sv
rtl/core/iaub_divider.sv
rtl/core/inverse_alpha_unblend_unit.sv
rtl/core/iaub_checker.sv
tb/tb.sv
